// ===== design/small_uniform_coeff_rejection_sampler_top_macros.svh =====
// Assertion macros shared by the rejection sampler modules.
`ifndef SMALL_UNIFORM_COEFF_REJECTION_SAMPLER_TOP_MACROS_SVH
`define SMALL_UNIFORM_COEFF_REJECTION_SAMPLER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SUCRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SUCRS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/sucrs_pkg.sv =====
// Package: constants, job type and digit arithmetic of the rejection sampler.
`default_nettype none
package sucrs_pkg;

  localparam int NUM_COEFFS = 256;
  localparam int CNT_W      = $clog2(NUM_COEFFS + 1);
  localparam int IDX_W      = 8;
  localparam int USED_W     = 12;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] MODE_TERNARY = 2'd0;
  localparam logic [1:0] MODE_PENTARY = 2'd1;
  localparam logic [1:0] MODE_PACKED  = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_RESET   = MODE_PENTARY;

  localparam logic [7:0] TERN_LIMIT = 8'd243;
  localparam logic [6:0] PENT_LIMIT = 7'd125;

  // One queued job: up to two digit groups that share a base.
  typedef struct packed {
    logic              base5;
    logic [7:0]        val_a;
    logic [2:0]        cnt_a;
    logic [6:0]        val_b;
    logic [1:0]        cnt_b;
    logic [IDX_W-1:0]  idx;
    logic              done;
    logic [USED_W-1:0] used;
  } sucrs_job_t;

  // Quotient by 3 or 5 through a reciprocal; exact for all 8-bit values.
  function automatic logic [7:0] div_base(logic [7:0] v, logic b5);
    logic [16:0] p3;
    logic [17:0] p5;
    p3 = 17'(v) * 17'd171;
    p5 = 18'(v) * 18'd205;
    return b5 ? 8'(p5 >> 10) : 8'(p3 >> 9);
  endfunction

  function automatic logic [2:0] mod_base(logic [7:0] v, logic b5);
    logic [7:0] q;
    logic [9:0] back;
    q    = div_base(v, b5);
    back = b5 ? 10'(q) * 10'd5 : 10'(q) * 10'd3;
    return 3'(10'(v) - back);
  endfunction

endpackage
`default_nettype wire

// ===== design/sucrs_front.sv =====
// Front end: takes bytes, keeps the polynomial counters and emits digit jobs.
`default_nettype none
module sucrs_front
  import sucrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       rand_byte,
  input  wire logic             first,
  input  wire logic             q_full,
  output logic                  push,
  output sucrs_job_t            job
);

  logic [1:0]        sample_mode;
  logic [CNT_W-1:0]  coeff_count, coeff_count_next;
  logic [USED_W-1:0] byte_count, byte_count_next;
  logic [5:0]        bit_store, bit_store_next;
  logic [2:0]        bit_fill, bit_fill_next;
  logic              finished, finished_next;

  logic [CNT_W-1:0]  cc_e;
  logic [USED_W-1:0] bc_e, bc_inc;
  logic [5:0]        bs_e;
  logic [2:0]        bf_e, nbf;
  logic              fin_e;
  logic              job_push;
  logic              accept;

  logic [CNT_W-1:0]  room, rem, rem2;
  logic [2:0]        ndig, n1;
  logic [1:0]        n2;
  logic [13:0]       acc;
  logic [6:0]        chunk1, chunk2;
  logic [6:0]        bmask;
  logic              ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && job_push;

  always_comb begin
    cc_e   = first ? '0 : coeff_count;
    bc_e   = first ? '0 : byte_count;
    bs_e   = first ? '0 : bit_store;
    bf_e   = first ? '0 : bit_fill;
    fin_e  = first ? 1'b0 : finished;
    bc_inc = (bc_e == {USED_W{1'b1}}) ? bc_e : bc_e + 1'b1;

    room   = CNT_W'(NUM_COEFFS - 1) - cc_e;
    rem    = CNT_W'(NUM_COEFFS) - cc_e;
    acc    = {bs_e, rand_byte};
    chunk1 = 7'(acc >> (4'(bf_e) + 4'd1));
    chunk2 = acc[6:0];
    nbf    = (bf_e == 3'd6) ? 3'd0 : bf_e + 3'd1;
    bmask  = (7'd1 << nbf) - 7'd1;
    ok     = 1'b0;
    ndig   = '0;
    n1     = '0;
    n2     = '0;
    rem2   = '0;

    coeff_count_next = cc_e;
    byte_count_next  = bc_e;
    bit_store_next   = bs_e;
    bit_fill_next    = bf_e;
    finished_next    = fin_e;
    job_push         = 1'b0;
    job              = '0;
    job.base5        = (sample_mode != MODE_TERNARY);

    if (!fin_e) begin
      unique case (sample_mode)
        MODE_TERNARY, MODE_PENTARY: begin
          if (cc_e >= CNT_W'(NUM_COEFFS - 1)) begin
            // final coefficient straight from the byte, no rejection
            job_push         = 1'b1;
            job.val_a        = rand_byte;
            job.cnt_a        = 3'd1;
            job.idx          = IDX_W'(NUM_COEFFS - 1);
            job.done         = 1'b1;
            job.used         = bc_e;
            coeff_count_next = CNT_W'(NUM_COEFFS);
            finished_next    = 1'b1;
          end else begin
            byte_count_next = bc_inc;
            if (sample_mode == MODE_TERNARY) begin
              ok        = rand_byte < TERN_LIMIT;
              job.val_a = rand_byte;
              ndig      = (room < CNT_W'(5)) ? 3'(room) : 3'd5;
            end else begin
              ok        = rand_byte[7:1] < PENT_LIMIT;
              job.val_a = {1'b0, rand_byte[7:1]};
              ndig      = (room < CNT_W'(3)) ? 3'(room) : 3'd3;
            end
            if (ok) begin
              job_push         = 1'b1;
              job.cnt_a        = ndig;
              job.idx          = IDX_W'(cc_e);
              coeff_count_next = cc_e + CNT_W'(ndig);
            end
          end
        end
        MODE_PACKED: begin
          byte_count_next = bc_inc;
          bit_fill_next   = nbf;
          bit_store_next  = acc[5:0] & bmask[5:0];
          if (chunk1 < PENT_LIMIT) begin
            n1 = (rem < CNT_W'(3)) ? 3'(rem) : 3'd3;
          end
          rem2 = rem - CNT_W'(n1);
          // second chunk only exists when six bits were pending
          if (bf_e == 3'd6 && chunk2 < PENT_LIMIT && rem2 != '0) begin
            n2 = (rem2 < CNT_W'(3)) ? 2'(rem2) : 2'd3;
          end
          job.val_a        = {1'b0, chunk1};
          job.cnt_a        = n1;
          job.val_b        = chunk2;
          job.cnt_b        = n2;
          job.idx          = IDX_W'(cc_e);
          job.done         = (CNT_W'(n1) + CNT_W'(n2)) == rem;
          job.used         = job.done ? bc_e : '0;
          job_push         = (n1 != '0) || (n2 != '0);
          coeff_count_next = cc_e + CNT_W'(n1) + CNT_W'(n2);
          finished_next    = job.done;
        end
        default: begin
          // unused mode: drop the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= MODE_RESET;
      coeff_count <= '0;
      byte_count  <= '0;
      bit_store   <= '0;
      bit_fill    <= '0;
      finished    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_mode <= cfg_wdata;
      end
      if (accept) begin
        coeff_count <= coeff_count_next;
        byte_count  <= byte_count_next;
        bit_store   <= bit_store_next;
        bit_fill    <= bit_fill_next;
        finished    <= finished_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sucrs_queue.sv =====
// Job queue between the front end and the digit serializer.
`default_nettype none
`include "small_uniform_coeff_rejection_sampler_top_macros.svh"
module sucrs_queue
  import sucrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  sucrs_job_t      push_job,
  output logic            full,
  input  wire logic       pop,
  output logic            q_valid,
  output sucrs_job_t      head
);

  sucrs_job_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SUCRS_NEVER(a_push_full, push && full, "job queue overflow")
  `SUCRS_NEVER(a_pop_empty, pop && !q_valid, "job queue underflow")
  `SUCRS_ASSERT(a_count_range, count <= Q_CNT_W'(Q_DEPTH), "job queue count out of range")

endmodule
`default_nettype wire

// ===== design/sucrs_back.sv =====
// Back end: serializes queued jobs into one coefficient beat per cycle while out_stall is low.
`default_nettype none
`include "small_uniform_coeff_rejection_sampler_top_macros.svh"
module sucrs_back
  import sucrs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  sucrs_job_t              head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [2:0]       coefficient,
  output logic [IDX_W-1:0]        coeff_index,
  output logic                    poly_done,
  output logic [USED_W-1:0]       bytes_used
);

  sucrs_job_t       cur;
  logic             cur_valid;
  logic [7:0]       work;
  logic [2:0]       left_a;
  logic [1:0]       left_b;
  logic [IDX_W-1:0] idx;

  logic             emit, last;
  logic [2:0]       digit;
  logic [7:0]       quo;

  assign emit  = cur_valid && (!out_valid || !out_stall);
  assign last  = (left_a == 3'd1 && left_b == 2'd0) || (left_a == 3'd0 && left_b == 2'd1);
  assign pop   = q_valid && (!cur_valid || (emit && last));
  assign digit = mod_base(work, cur.base5);
  assign quo   = div_base(work, cur.base5);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= head;
      work   <= (head.cnt_a != '0) ? head.val_a : {1'b0, head.val_b};
      left_a <= head.cnt_a;
      left_b <= head.cnt_b;
      idx    <= head.idx;
    end else if (emit) begin
      idx <= idx + 1'b1;
      if (left_a != '0) begin
        left_a <= left_a - 1'b1;
        // switch to the second chunk once the first runs out
        work   <= (left_a == 3'd1) ? {1'b0, cur.val_b} : quo;
      end else begin
        left_b <= left_b - 1'b1;
        work   <= quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coefficient <= $signed(digit - (cur.base5 ? 3'd2 : 3'd1));
      coeff_index <= idx;
      poly_done   <= cur.done && last;
      bytes_used  <= (cur.done && last) ? cur.used : '0;
    end
  end

  `SUCRS_NEVER(a_cur_empty, cur_valid && left_a == '0 && left_b == '0, "job with no digits")
  `SUCRS_ASSERT(a_done_idx, out_valid && poly_done |-> coeff_index == IDX_W'(NUM_COEFFS - 1), "done off last index")
  `SUCRS_ASSERT(a_used_zero, out_valid && !poly_done |-> bytes_used == '0, "byte count without done")

endmodule
`default_nettype wire

// ===== design/small_uniform_coeff_rejection_sampler_top.sv =====
// Top level of the small-coefficient rejection sampler.
// Usage:
//   Input channel: rand_byte and first with in_valid/in_stall; a beat moves when
//   in_valid is high and in_stall is low. first=1 starts a new polynomial.
//   Output channel: coefficient, coeff_index, poly_done, bytes_used with
//   out_valid/out_stall; bytes_used is nonzero only with poly_done.
//   Config: cfg_we/cfg_wdata write sample_mode (reset value 1); write it only
//   while no bytes are in flight.
// Timing:
//   A byte's first coefficient passes a queue entry, the back end's job register
//   and the output register. The output register carries one coefficient per
//   cycle while out_stall is low; a byte yields up to five (six when two packed
//   chunks land in one byte), a rejected byte none. A four-entry job queue lets
//   bytes keep arriving while earlier coefficients drain.
// Reset clears the counters, the queue and the output valid; the mode returns
// to 1. While out_stall is high the output beat holds; the queue fills and then
// in_stall rises until the receiver takes beats again.
`default_nettype none
module small_uniform_coeff_rejection_sampler_top
  import sucrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        rand_byte,
  input  wire logic              first,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [2:0]      coefficient,
  output logic [IDX_W-1:0]       coeff_index,
  output logic                   poly_done,
  output logic [USED_W-1:0]      bytes_used
);

  sucrs_job_t push_job, head;
  logic       push, full, pop, q_valid;

  sucrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rand_byte (rand_byte),
    .first     (first),
    .q_full    (full),
    .push      (push),
    .job       (push_job)
  );

  sucrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  sucrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coefficient (coefficient),
    .coeff_index (coeff_index),
    .poly_done   (poly_done),
    .bytes_used  (bytes_used)
  );

endmodule
`default_nettype wire
